// File: hdl/iba_pkg.sv
package iba_pkg;

  // Default sizes of the bitmap store
  localparam int unsigned MAX_GROUPS_DEF   = 16;
  localparam int unsigned BITMAP_BYTES_DEF = 1024;

  // Field widths of the item ports
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned GSEL_W = 4;
  localparam int unsigned BIDX_W = 10;
  localparam int unsigned VAL_W  = 18;

  // Register widths
  localparam int unsigned IPG_W  = 14;
  localparam int unsigned FUI_W  = 13;
  localparam int unsigned GC_W   = 5;
  localparam int unsigned CNT_W  = 14;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Widths for group and byte comparisons
  localparam int unsigned CMP_W  = 10;
  localparam int unsigned BCMP_W = 14;

  // Register reset values
  localparam logic [IPG_W-1:0] IPG_RST = IPG_W'(2048);
  localparam logic [FUI_W-1:0] FUI_RST = FUI_W'(11);
  localparam logic [GC_W-1:0]  GC_RST  = GC_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_BYTE  = 2'd0,
    CMD_LOAD_COUNT = 2'd1,
    CMD_LOAD_TOTAL = 2'd2,
    CMD_ALLOCATE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INODES_PER_GROUP = 2'd0,
    CFG_FIRST_INODE      = 2'd1,
    CFG_GROUP_COUNT      = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

endpackage

// File: hdl/iba_ram.sv
module iba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/inode_bitmap_allocator_unit.sv
// Inode bitmap allocator. Load items are answered at once when the result
// register is free, and wait in the response state while it is still held. An
// allocate item is worked by one sequencer over a bitmap RAM with one write
// port and one registered read port: it takes the item, then visits the group
// state for each group it looks at and reads each bitmap byte in a read state
// and a check state (read, then test and write back), and then posts the
// result. A walk that runs out of groups makes one more pass through the group
// state before it reports full. The next item is taken only after the result
// is posted; the worst case walks every byte of every group.
// An allocate with a zero total is answered like a load. in_stall_o stays
// high for the whole allocation and while a result waits for the result
// register. The bitmap RAM is not cleared: every byte must be loaded before
// an allocation can reach it. Configuration writes are taken at any time and
// must only be made while the block is idle.
module inode_bitmap_allocator_unit #(
  parameter int unsigned MAX_GROUPS   = iba_pkg::MAX_GROUPS_DEF,
  parameter int unsigned BITMAP_BYTES = iba_pkg::BITMAP_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [iba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [iba_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [iba_pkg::CMD_W-1:0]         command_i,
  input  logic [iba_pkg::GSEL_W-1:0]        group_sel_i,
  input  logic [iba_pkg::BIDX_W-1:0]        byte_index_i,
  input  logic [iba_pkg::VAL_W-1:0]         load_value_i,
  // Result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic [iba_pkg::VAL_W-1:0]         inode_number_o
);

  localparam int unsigned GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned GCW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned BIW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned DEPTH = MAX_GROUPS * BITMAP_BYTES;
  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned GPW = GIW + iba_pkg::IPG_W;
  localparam int unsigned CW  = iba_pkg::CMP_W;
  localparam int unsigned BCW = iba_pkg::BCMP_W;
  localparam int unsigned VW  = iba_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_e;

  state_e st_q, st_d;

  // Registers
  logic [iba_pkg::IPG_W-1:0] ipg_q, ipg_d;
  logic [iba_pkg::FUI_W-1:0] fui_q, fui_d;
  logic [iba_pkg::GC_W-1:0]  gc_q, gc_d;
  logic [iba_pkg::CNT_W-1:0] cnt_q [MAX_GROUPS];
  logic [iba_pkg::CNT_W-1:0] cnt_d [MAX_GROUPS];
  logic [VW-1:0]             tot_q, tot_d;

  // Sequencer working state
  logic [GCW-1:0]            cur_g_q, cur_g_d;
  logic [iba_pkg::GSEL_W-1:0] gsel_q, gsel_d;
  logic                      sugg_q, sugg_d;
  logic [BIW-1:0]            byte_q, byte_d;
  logic                      first_q, first_d;
  logic [VW-1:0]             prod_q, prod_d;
  logic                      res_status_q, res_status_d;
  logic [VW-1:0]             res_number_q, res_number_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic                      out_status_q, out_status_d;
  logic [VW-1:0]             out_number_q, out_number_d;

  // RAM port
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [7:0]                ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [7:0]                ram_rdata;

  // Combinational helpers
  logic                      in_acc;
  logic                      out_free;
  logic [CW-1:0]             n_ext;
  logic [CW-1:0]             g_ext;
  logic [CW-1:0]             gsel_ext;
  logic [CW-1:0]             in_gsel_ext;
  logic [GIW-1:0]            g_idx;
  logic [iba_pkg::CNT_W-1:0] cnt_rd;
  logic [BCW-1:0]            start_ext;
  logic                      start_past_end;
  logic [AW-1:0]             scan_addr;
  logic [2:0]                rem;
  logic [7:0]                low_mask;
  logic [7:0]                masked;
  logic                      found;
  logic [2:0]                zero_pos;
  logic [GPW-1:0]            prod_full;

  iba_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (st_q != ST_IDLE);
  assign in_acc         = in_valid_i && (st_q == ST_IDLE);
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign inode_number_o = out_number_q;

  // Group bookkeeping
  assign n_ext = (CW'(gc_q) > CW'(MAX_GROUPS)) ? CW'(MAX_GROUPS) : CW'(gc_q);
  assign g_ext       = CW'(cur_g_q);
  assign gsel_ext    = CW'(gsel_q);
  assign in_gsel_ext = CW'(group_sel_i);
  assign g_idx       = cur_g_q[GIW-1:0];
  assign cnt_rd      = (g_ext < CW'(MAX_GROUPS)) ? cnt_q[g_idx] : '0;
  assign start_ext   = BCW'(fui_q >> 3);
  assign start_past_end = (start_ext >= BCW'(BITMAP_BYTES));
  assign prod_full   = GPW'(g_idx) * GPW'(ipg_q);
  assign scan_addr   = AW'(g_idx) * AW'(BITMAP_BYTES) + AW'(byte_q);
  assign ram_raddr   = scan_addr;

  // Find the lowest clear bit, ignoring bits below the start in group 0
  assign rem      = (first_q && (g_ext == '0)) ? fui_q[2:0] : 3'd0;
  assign low_mask = (8'd1 << rem) - 8'd1;
  assign masked   = ram_rdata | low_mask;
  assign found    = (masked != iba_pkg::BYTE_FULL);

  always_comb begin
    zero_pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!masked[k]) begin
        zero_pos = 3'(k);
      end
    end
  end

  // Next-state logic
  always_comb begin
    st_d         = st_q;
    ipg_d        = ipg_q;
    fui_d        = fui_q;
    gc_d         = gc_q;
    cnt_d        = cnt_q;
    tot_d        = tot_q;
    cur_g_d      = cur_g_q;
    gsel_d       = gsel_q;
    sugg_d       = sugg_q;
    byte_d       = byte_q;
    first_d      = first_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_number_d = res_number_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_number_d = out_number_q;
    ram_we       = 1'b0;
    ram_waddr    = scan_addr;
    ram_wdata    = ram_rdata | (8'd1 << zero_pos);

    // Take configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        iba_pkg::CFG_INODES_PER_GROUP: ipg_d = cfg_data_i[iba_pkg::IPG_W-1:0];
        iba_pkg::CFG_FIRST_INODE:      fui_d = cfg_data_i[iba_pkg::FUI_W-1:0];
        iba_pkg::CFG_GROUP_COUNT:      gc_d  = cfg_data_i[iba_pkg::GC_W-1:0];
        default: ;
      endcase
    end

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_status_d = 1'b0;
          res_number_d = '0;
          case (command_i)
            iba_pkg::CMD_LOAD_BYTE: begin
              if (in_gsel_ext < CW'(MAX_GROUPS) &&
                  BCW'(byte_index_i) < BCW'(BITMAP_BYTES)) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(GIW'(group_sel_i)) * AW'(BITMAP_BYTES) +
                            AW'(BIW'(byte_index_i));
                ram_wdata = load_value_i[7:0];
              end
            end
            iba_pkg::CMD_LOAD_COUNT: begin
              if (in_gsel_ext < CW'(MAX_GROUPS)) begin
                cnt_d[GIW'(group_sel_i)] = load_value_i[iba_pkg::CNT_W-1:0];
              end
            end
            iba_pkg::CMD_LOAD_TOTAL: begin
              tot_d = load_value_i;
            end
            default: begin
              if (tot_q == '0) begin
                res_status_d = 1'b1;
              end
            end
          endcase

          // Start an allocation, or post the result at once when the result register is free
          if (command_i == iba_pkg::CMD_ALLOCATE && tot_q != '0) begin
            gsel_d  = group_sel_i;
            sugg_d  = (in_gsel_ext < n_ext);
            cur_g_d = (in_gsel_ext < n_ext) ? GCW'(group_sel_i) : '0;
            st_d    = ST_GROUP;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = res_status_d;
            out_number_d = '0;
          end else begin
            st_d = ST_RESP;
          end
        end
      end

      ST_GROUP: begin
        if (!sugg_q && g_ext >= n_ext) begin
          // No group left: report full
          res_status_d = 1'b1;
          res_number_d = '0;
          st_d         = ST_RESP;
        end else if ((!sugg_q && g_ext == gsel_ext) || cnt_rd == '0 ||
                     (g_ext == '0 && start_past_end)) begin
          // Skip this group
          if (sugg_q) begin
            sugg_d  = 1'b0;
            cur_g_d = '0;
          end else begin
            cur_g_d = cur_g_q + GCW'(1);
          end
        end else begin
          byte_d  = (g_ext == '0) ? BIW'(start_ext) : '0;
          first_d = 1'b1;
          prod_d  = VW'(prod_full);
          st_d    = ST_READ;
        end
      end

      ST_READ: begin
        st_d = ST_CHECK;
      end

      ST_CHECK: begin
        first_d = 1'b0;
        if (found) begin
          ram_we       = 1'b1;
          cnt_d[g_idx] = cnt_q[g_idx] - iba_pkg::CNT_W'(1);
          tot_d        = tot_q - VW'(1);
          res_status_d = 1'b0;
          res_number_d = prod_q + VW'({byte_q, zero_pos}) + VW'(1);
          st_d         = ST_RESP;
        end else if (byte_q == BIW'(BITMAP_BYTES - 1)) begin
          // End of this group's bitmap: move on
          st_d = ST_GROUP;
          if (sugg_q) begin
            sugg_d  = 1'b0;
            cur_g_d = '0;
          end else begin
            cur_g_d = cur_g_q + GCW'(1);
          end
        end else begin
          byte_d = byte_q + BIW'(1);
          st_d   = ST_READ;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_number_d = res_number_q;
          st_d         = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ipg_q       <= iba_pkg::IPG_RST;
      fui_q       <= iba_pkg::FUI_RST;
      gc_q        <= iba_pkg::GC_RST;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
      sugg_q      <= 1'b0;
      first_q     <= 1'b0;
      cur_g_q     <= '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        cnt_q[g] <= '0;
      end
    end else begin
      st_q        <= st_d;
      ipg_q       <= ipg_d;
      fui_q       <= fui_d;
      gc_q        <= gc_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
      sugg_q      <= sugg_d;
      first_q     <= first_d;
      cur_g_q     <= cur_g_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    gsel_q       <= gsel_d;
    byte_q       <= byte_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_number_q <= res_number_d;
    out_status_q <= out_status_d;
    out_number_q <= out_number_d;
  end

  // The total only moves on a total load or on a find
  a_total_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_q != $past(tot_q)) |->
      ($past(st_q == ST_CHECK && found) ||
       $past(in_acc && command_i == iba_pkg::CMD_LOAD_TOTAL)))
    else $error("total free count changed without a find or load");

  // A new result comes only from an idle load or the response state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_IDLE || st_q == ST_RESP))
    else $error("result posted from a scanning state");

  // A failed allocation carries inode number zero
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_number_q == '0))
    else $error("full status with nonzero inode number");

  // The scan never addresses a group beyond the store
  a_scan_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ || st_q == ST_CHECK) |-> (g_ext < CW'(MAX_GROUPS)))
    else $error("scan group out of range");

endmodule
